// ===== src/touch_tap_long_press_detector_macros.svh =====
// Assertion macros shared by the tap and long-press detector modules
`ifndef TOUCH_TAP_LONG_PRESS_DETECTOR_MACROS_SVH
`define TOUCH_TAP_LONG_PRESS_DETECTOR_MACROS_SVH

// Same-cycle implication, checked outside reset
`define TTLP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ttlp assertion failed");

// Next-cycle implication, checked outside reset
`define TTLP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ttlp assertion failed");

`endif

// ===== src/ttlp_pkg.sv =====
// Shared types and constants for the tap and long-press detector
`default_nettype none

package ttlp_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 16;
   localparam int CFG_WIDTH           = 16;
   localparam int CSR_INDEX_WIDTH     = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TOUCH_POLARITY   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GUARD_TICKS      = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_PRESS_TICKS = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_POLL_TICKS       = 2'd3;

   localparam logic                 TOUCH_POLARITY_RESET   = 1'b1;
   localparam logic [CFG_WIDTH-1:0] GUARD_TICKS_RESET      = 16'd20;
   localparam logic [CFG_WIDTH-1:0] LONG_PRESS_TICKS_RESET = 16'd200;
   localparam logic [CFG_WIDTH-1:0] POLL_TICKS_RESET       = 16'd50;

   typedef enum logic [1:0] {
      GESTURE_NONE    = 2'd0,
      GESTURE_TAP     = 2'd1,
      GESTURE_LONG    = 2'd2,
      GESTURE_RELEASE = 2'd3
   } gesture_type;

   typedef struct packed {
      logic                 touch_polarity;
      logic [CFG_WIDTH-1:0] guard_ticks;
      logic [CFG_WIDTH-1:0] long_press_ticks;
      logic [CFG_WIDTH-1:0] poll_ticks;
   } cfg_type;

endpackage

`default_nettype wire

// ===== src/ttlp_req_if.sv =====
// Input channel carrying one sampled pin level per beat
`default_nettype none

interface ttlp_req_if;
   logic valid;
   logic ready;
   logic pin_level;

   modport source (output valid, output pin_level, input ready);
   modport sink (input valid, input pin_level, output ready);
endinterface

`default_nettype wire

// ===== src/ttlp_rsp_if.sv =====
// Result channel carrying one gesture code per beat
`default_nettype none

interface ttlp_rsp_if;
   logic                  valid;
   logic                  ready;
   ttlp_pkg::gesture_type gesture;

   modport source (output valid, output gesture, input ready);
   modport sink (input valid, input gesture, output ready);
endinterface

`default_nettype wire

// ===== src/ttlp_core.sv =====
// Debounce, press tracking and long-press countdown, one tick per step
`default_nettype none

`include "touch_tap_long_press_detector_macros.svh"

module ttlp_core #(
   parameter int COUNT_WIDTH = ttlp_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic                  pin_level,
   input  wire ttlp_pkg::cfg_type     cfg,
   output ttlp_pkg::gesture_type      gesture
);

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

   function automatic logic [COUNT_WIDTH-1:0] clamp_period(
      input logic [ttlp_pkg::CFG_WIDTH-1:0] period
   );
      logic [COUNT_WIDTH-1:0] result;
      if (period == '0) begin
         result = COUNT_WIDTH'(1);
      end else if (32'(period) > 32'(CNT_MAX)) begin
         result = CNT_MAX;
      end else begin
         result = COUNT_WIDTH'(period);
      end
      return result;
   endfunction

   logic                   prev_level_ff, prev_level_in;
   logic [COUNT_WIDTH-1:0] since_edge_ff, since_edge_in;
   logic                   pressed_ff, pressed_in;
   logic                   long_flag_ff, long_flag_in;
   logic                   timer_running_ff, timer_running_in;
   logic [COUNT_WIDTH-1:0] timer_count_ff, timer_count_in;

   logic [COUNT_WIDTH-1:0] elapsed;
   logic [COUNT_WIDTH-1:0] count_dec;
   logic                   active;
   logic                   edge_ok;
   logic                   press_start;
   logic                   press_stop;

   assign elapsed   = (since_edge_ff == CNT_MAX) ? CNT_MAX : since_edge_ff + 1'b1;
   assign count_dec = (timer_count_ff == '0) ? '0 : timer_count_ff - 1'b1;
   assign active    = (pin_level == cfg.touch_polarity);
   assign edge_ok   = (pin_level != prev_level_ff) &&
                      (32'(elapsed) >= 32'(cfg.guard_ticks));
   assign press_start = edge_ok && active && !pressed_ff;
   assign press_stop  = edge_ok && !active && pressed_ff;

   always_comb begin
      prev_level_in    = pin_level;
      since_edge_in    = edge_ok ? '0 : elapsed;
      pressed_in       = pressed_ff;
      long_flag_in     = long_flag_ff;
      timer_running_in = timer_running_ff;
      timer_count_in   = timer_count_ff;
      gesture          = ttlp_pkg::GESTURE_NONE;

      if (press_start) begin
         pressed_in       = 1'b1;
         long_flag_in     = 1'b0;
         timer_count_in   = clamp_period(cfg.long_press_ticks);
         timer_running_in = 1'b1;
      end else if (press_stop) begin
         pressed_in       = 1'b0;
         timer_running_in = 1'b0;
         timer_count_in   = '0;
         long_flag_in     = 1'b0;
         gesture          = long_flag_ff ? ttlp_pkg::GESTURE_RELEASE : ttlp_pkg::GESTURE_TAP;
      end else if (timer_running_ff) begin
         timer_count_in = count_dec;
         if (count_dec == '0) begin
            timer_running_in = 1'b0;
            if (!active) begin
               if (long_flag_ff) begin
                  pressed_in   = 1'b0;
                  long_flag_in = 1'b0;
                  gesture      = ttlp_pkg::GESTURE_RELEASE;
               end else if (pressed_ff) begin
                  pressed_in = 1'b0;
                  gesture    = ttlp_pkg::GESTURE_TAP;
               end
            end else begin
               if (!long_flag_ff) begin
                  long_flag_in = 1'b1;
                  gesture      = ttlp_pkg::GESTURE_LONG;
               end
               timer_count_in   = clamp_period(cfg.poll_ticks);
               timer_running_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff    <= 1'b0;
         since_edge_ff    <= CNT_MAX;
         pressed_ff       <= 1'b0;
         long_flag_ff     <= 1'b0;
         timer_running_ff <= 1'b0;
         timer_count_ff   <= '0;
      end else if (step) begin
         prev_level_ff    <= prev_level_in;
         since_edge_ff    <= since_edge_in;
         pressed_ff       <= pressed_in;
         long_flag_ff     <= long_flag_in;
         timer_running_ff <= timer_running_in;
         timer_count_ff   <= timer_count_in;
      end
   end

   `TTLP_ASSERT_NOW(a_press_tracks_timer, clock, reset, 1'b1, pressed_ff == timer_running_ff)
   `TTLP_ASSERT_NOW(a_long_needs_press, clock, reset, long_flag_ff, pressed_ff)
   `TTLP_ASSERT_NOW(a_timer_nonzero, clock, reset, timer_running_ff, timer_count_ff != '0)
   `TTLP_ASSERT_NEXT(a_gesture_settles, clock, reset,
      step && (gesture != ttlp_pkg::GESTURE_NONE), !pressed_ff || long_flag_ff)

endmodule

`default_nettype wire

// ===== src/ttlp_out_buf.sv =====
// Result register with a skid stage so one more input beat is taken during a stall
`default_nettype none

`include "touch_tap_long_press_detector_macros.svh"

module ttlp_out_buf (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire ttlp_pkg::gesture_type in_gesture,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output ttlp_pkg::gesture_type      out_gesture
);

   logic                  out_valid_ff;
   ttlp_pkg::gesture_type out_gesture_ff;
   logic                  skid_valid_ff;
   ttlp_pkg::gesture_type skid_gesture_ff;

   logic                  take_in;
   logic                  take_out;

   assign in_ready    = !skid_valid_ff;
   assign take_in     = in_valid && in_ready;
   assign take_out    = out_valid_ff && out_ready;
   assign out_valid   = out_valid_ff;
   assign out_gesture = out_gesture_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take_out) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (take_in) begin
         if (!out_valid_ff || take_out) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take_out) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take_out) begin
            out_gesture_ff <= skid_gesture_ff;
         end
      end else if (take_in) begin
         if (!out_valid_ff || take_out) begin
            out_gesture_ff <= in_gesture;
         end else begin
            skid_gesture_ff <= in_gesture;
         end
      end
   end

   `TTLP_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `TTLP_ASSERT_NEXT(a_stall_fills_skid, clock, reset,
      take_in && out_valid_ff && !out_ready, skid_valid_ff)

endmodule

`default_nettype wire

// ===== src/touch_tap_long_press_detector.sv =====
// Top level: tap, long-press and release detection on a debounced touch pin
// Each pin beat taken on req yields a gesture, registered in the result buffer.
// Throughput: one pin beat per cycle while the skid stage is empty; the gesture
// logic is one registered pass; a two-deep buffer takes one more beat in a stall.
// Reset is synchronous: registers return to their reset values, debounce saturated,
// no press active, result buffer empty.
`default_nettype none

module touch_tap_long_press_detector #(
   parameter int COUNT_WIDTH = ttlp_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   ttlp_req_if.sink                                   req_chan,
   ttlp_rsp_if.source                                 rsp_chan,
   input  wire logic                                  csr_wr_en,
   input  wire logic [ttlp_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [ttlp_pkg::CFG_WIDTH-1:0]        csr_wdata
);

   ttlp_pkg::cfg_type     cfg_ff;
   ttlp_pkg::gesture_type step_gesture;
   logic                  step;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.touch_polarity   <= ttlp_pkg::TOUCH_POLARITY_RESET;
         cfg_ff.guard_ticks      <= ttlp_pkg::GUARD_TICKS_RESET;
         cfg_ff.long_press_ticks <= ttlp_pkg::LONG_PRESS_TICKS_RESET;
         cfg_ff.poll_ticks       <= ttlp_pkg::POLL_TICKS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            ttlp_pkg::CSR_TOUCH_POLARITY:   cfg_ff.touch_polarity   <= csr_wdata[0];
            ttlp_pkg::CSR_GUARD_TICKS:      cfg_ff.guard_ticks      <= csr_wdata;
            ttlp_pkg::CSR_LONG_PRESS_TICKS: cfg_ff.long_press_ticks <= csr_wdata;
            ttlp_pkg::CSR_POLL_TICKS:       cfg_ff.poll_ticks       <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign step = req_chan.valid && req_chan.ready;

   ttlp_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .pin_level (req_chan.pin_level),
      .cfg       (cfg_ff),
      .gesture   (step_gesture)
   );

   ttlp_out_buf u_out_buf (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_chan.valid),
      .in_ready    (req_chan.ready),
      .in_gesture  (step_gesture),
      .out_valid   (rsp_chan.valid),
      .out_ready   (rsp_chan.ready),
      .out_gesture (rsp_chan.gesture)
   );

endmodule

`default_nettype wire

// ===== sim/tb_touch_tap_long_press_detector.sv =====
// Self-checking testbench for the touch tap and long-press detector, with a gesture tracker
module tb_touch_tap_long_press_detector;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned MAX_SEGMENT = 400;
   localparam int          CW          = ttlp_pkg::COUNT_WIDTH_DEFAULT;
   localparam int          FW          = ttlp_pkg::CFG_WIDTH;
   localparam int          IW          = ttlp_pkg::CSR_INDEX_WIDTH;

   class gesture_tracker;
      logic                           touch_polarity;
      logic [FW-1:0]                  guard_ticks;
      logic [FW-1:0]                  long_press_ticks;
      logic [FW-1:0]                  poll_ticks;
      logic                           prev_level;
      logic [CW-1:0]                  since_edge;
      logic                           pressed;
      logic                           long_flag;
      logic                           timer_running;
      logic [CW-1:0]                  timer_count;
      ttlp_pkg::gesture_type          awaited[$];
      int unsigned                    faults;

      function new();
         touch_polarity   = ttlp_pkg::TOUCH_POLARITY_RESET;
         guard_ticks      = ttlp_pkg::GUARD_TICKS_RESET;
         long_press_ticks = ttlp_pkg::LONG_PRESS_TICKS_RESET;
         poll_ticks       = ttlp_pkg::POLL_TICKS_RESET;
         prev_level       = 1'b0;
         since_edge       = '1;
         pressed          = 1'b0;
         long_flag        = 1'b0;
         timer_running    = 1'b0;
         timer_count      = '0;
         faults           = 0;
      endfunction

      function void set_register(logic [IW-1:0] idx, logic [FW-1:0] data);
         case (idx)
            ttlp_pkg::CSR_TOUCH_POLARITY:   touch_polarity = data[0];
            ttlp_pkg::CSR_GUARD_TICKS:      guard_ticks = data;
            ttlp_pkg::CSR_LONG_PRESS_TICKS: long_press_ticks = data;
            ttlp_pkg::CSR_POLL_TICKS:       poll_ticks = data;
            default: ;
         endcase
      endfunction

      // zero period counts as one tick
      function void load_countdown(logic [FW-1:0] period);
         timer_count   = (period == '0) ? CW'(1) : CW'(period);
         timer_running = 1'b1;
      endfunction

      function void take_pin_sample(logic level);
         logic                  is_active;
         logic                  edge_taken;
         ttlp_pkg::gesture_type result;
         is_active  = (level == touch_polarity);
         edge_taken = 1'b0;
         result     = ttlp_pkg::GESTURE_NONE;
         if (since_edge != '1) since_edge++;
         if (level != prev_level && since_edge >= guard_ticks) begin
            since_edge = '0;
            if (is_active && !pressed) begin
               pressed    = 1'b1;
               long_flag  = 1'b0;
               load_countdown(long_press_ticks);
               edge_taken = 1'b1;
            end else if (!is_active && pressed) begin
               pressed       = 1'b0;
               timer_running = 1'b0;
               timer_count   = '0;
               result        = long_flag ? ttlp_pkg::GESTURE_RELEASE : ttlp_pkg::GESTURE_TAP;
               long_flag     = 1'b0;
               edge_taken    = 1'b1;
            end
         end
         prev_level = level;
         if (!edge_taken && timer_running) begin
            if (timer_count != '0) timer_count--;
            if (timer_count == '0) begin
               timer_running = 1'b0;
               if (!is_active) begin
                  if (long_flag) begin
                     pressed   = 1'b0;
                     long_flag = 1'b0;
                     result    = ttlp_pkg::GESTURE_RELEASE;
                  end else if (pressed) begin
                     pressed = 1'b0;
                     result  = ttlp_pkg::GESTURE_TAP;
                  end
               end else begin
                  if (!long_flag) begin
                     long_flag = 1'b1;
                     result    = ttlp_pkg::GESTURE_LONG;
                  end
                  load_countdown(poll_ticks);
               end
            end
         end
         awaited.push_back(result);
      endfunction

      task flag_mismatch(string msg);
         $display("MISMATCH: %s", msg);
         faults++;
      endtask

      task match_gesture(ttlp_pkg::gesture_type got);
         ttlp_pkg::gesture_type want;
         if (awaited.size() == 0) begin
            flag_mismatch($sformatf("gesture %0d with no beat awaiting a result", got));
         end else begin
            want = awaited.pop_front();
            if (got !== want)
               flag_mismatch($sformatf("gesture %0d, expected %0d", got, want));
         end
      endtask
   endclass

   logic                       clock;
   logic                       reset;
   logic                       csr_wr_en;
   logic [IW-1:0]              csr_index;
   logic [FW-1:0]              csr_wdata;
   bit                         req_calm;
   bit                         rsp_calm;
   int unsigned                cycles;
   gesture_tracker             tracker;

   ttlp_req_if req_bus();
   ttlp_rsp_if rsp_bus();

   touch_tap_long_press_detector DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("touch_tap_long_press_detector verification failed");
         $finish;
      end
   end

   task automatic send_tick(input bit level);
      int unsigned gap;
      if ($urandom_range(0, 29) == 0) req_calm = !req_calm;
      gap = req_calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.pin_level <= level;
      do @(posedge clock); while (!req_bus.ready);
      tracker.take_pin_sample(level);
      @(negedge clock);
   endtask

   // drop valid and hold until every awaited gesture is back
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (tracker.awaited.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic apply_setting(input bit ah, input int unsigned db, input int unsigned lp,
                                input int unsigned pl);
      logic [IW-1:0] regs[4];
      logic [FW-1:0] vals[4];
      regs = '{ttlp_pkg::CSR_TOUCH_POLARITY, ttlp_pkg::CSR_GUARD_TICKS,
               ttlp_pkg::CSR_LONG_PRESS_TICKS, ttlp_pkg::CSR_POLL_TICKS};
      vals = '{FW'(ah), FW'(db), FW'(lp), FW'(pl)};
      for (int i = 0; i < 4; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         tracker.set_register(regs[i], vals[i]);
         @(negedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   // hold lengths around the debounce, long-press and poll thresholds
   function automatic int unsigned segment_length();
      int r, lp, pl, db, len;
      r  = $urandom_range(0, 9);
      db = tracker.guard_ticks;
      lp = (tracker.long_press_ticks == 0) ? 1 : tracker.long_press_ticks;
      pl = (tracker.poll_ticks == 0) ? 1 : tracker.poll_ticks;
      if (r < 3)
         len = $urandom_range(1, 3);
      else if (r < 5)
         len = $urandom_range(1, (db + 2 > 40) ? 40 : db + 2);
      else if (r < 8)
         len = $urandom_range((lp > 3) ? lp - 2 : 1, lp + 2);
      else
         len = lp + pl * $urandom_range(0, 3) + $urandom_range(0, pl);
      return (len > MAX_SEGMENT) ? MAX_SEGMENT : len;
   endfunction

   task automatic run_random(input int unsigned count);
      int unsigned sent, len;
      bit          level;
      sent  = 0;
      level = $urandom_range(0, 1);
      while (sent < count) begin
         len = segment_length();
         for (int k = 0; k < len && sent < count; k++) begin
            send_tick(level);
            sent++;
         end
         level = ~level;
      end
   endtask

   initial begin
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         int unsigned gap;
         if ($urandom_range(0, 29) == 0) rsp_calm = !rsp_calm;
         gap = rsp_calm ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         tracker.match_gesture(rsp_bus.gesture);
         @(negedge clock);
      end
   end

   initial begin
      bit dir_a [9]  = '{1, 0, 1, 1, 1, 0, 1, 1, 0};
      bit dir_b [17] = '{1, 1, 1, 1, 0, 1, 1, 1, 1, 0, 0, 0, 0, 0, 1, 0, 1};
      tracker           = new();
      cycles            = 0;
      req_calm          = 1'b0;
      rsp_calm          = 1'b0;
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_index         = ttlp_pkg::CSR_TOUCH_POLARITY;
      csr_wdata         = '0;
      req_bus.valid     = 1'b0;
      req_bus.pin_level = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_random(250);
      settle();
      apply_setting(1'b1, 0, 1, 1);
      foreach (dir_a[i]) send_tick(dir_a[i]);
      settle();
      apply_setting(1'b0, 3, 2, 2);
      foreach (dir_b[i]) send_tick(dir_b[i]);
      settle();
      apply_setting(1'b1, 0, 1, 1);
      run_random(100);
      settle();
      apply_setting(1'b0, 2, 6, 3);
      run_random(120);
      settle();
      apply_setting(1'b1, 4, 10, 5);
      run_random(120);
      settle();
      apply_setting(1'b0, 0, 0, 0);
      run_random(60);
      settle();
      apply_setting(1'b1, 65535, 65535, 65535);
      run_random(50);
      settle();
      apply_setting($urandom_range(0, 1), $urandom_range(0, 6), $urandom_range(1, 20),
                    $urandom_range(1, 8));
      run_random(100);
      settle();
      repeat (5) @(negedge clock);

      if (tracker.faults == 0) begin
         $display("touch_tap_long_press_detector verification clean");
      end else begin
         $display("touch_tap_long_press_detector verification failed");
      end
      $finish;
   end

endmodule
